FILE: rtl/ppr3d_pkg.sv
// Shared codes and default sizes for the 3D point projection and reflection block.
package ppr3d_pkg;

   // Default coordinate format, signed fixed point
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Threshold register
   localparam int                    CSR_BITS  = 32;
   localparam logic [CSR_BITS-1:0]   CSR_RESET = 32'd1;

   typedef enum logic [1:0] {
      OP_LINE    = 2'd0,
      OP_PLANE   = 2'd1,
      OP_REFLECT = 2'd2,
      OP_INVALID = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DEGEN   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

endpackage

FILE: rtl/point_projection_reflection_3d.sv
// Pipelined projection of a 3D point onto a line or a plane, or reflection in the plane.
//
// One beat enters every cycle and one result beat leaves every cycle while rsp_tready
// stays high. The stages are: one for the products, one for the dot-product sums, one
// for the status and magnitudes, two for the split dividend multiply, one
// restoring-divider stage per quotient bit (COORD_BITS + 3 of them, one per axis in
// parallel) and one for rounding, the final add and saturation. A stall on the result
// side freezes the whole pipeline, so nothing is lost or repeated. csr_wr_data sets the
// minimum N.N (unsigned fixed point with FRAC_BITS fraction bits); write it only while
// the pipeline is empty.
module point_projection_reflection_3d #(
   parameter int COORD_BITS = ppr3d_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ppr3d_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // point x,y,z, anchor x,y,z, dir x,y,z, from the lowest bit up
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   // operation
   input  logic [1:0]                              req_tuser,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // result x,y,z, from the lowest bit up
   output logic [((3*COORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   // status
   output logic [1:0]                              rsp_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_wr_en,
   input  logic [ppr3d_pkg::CSR_BITS-1:0]          csr_wr_data
);
   import ppr3d_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int PW  = 2*CB;          // one square
   localparam int DW  = 2*CB + 2;      // N.N
   localparam int NW  = 2*CB + 3;      // (P-A).N, signed
   localparam int MW  = CB + 1;        // k*|N_i|
   localparam int LH  = (NW + 1) / 2;  // low part of the split multiply
   localparam int HW  = NW - LH;
   localparam int XW  = NW + MW;       // dividend
   localparam int QB  = CB + 3;        // quotient bits
   localparam int RW  = QB + 3;        // final sum
   localparam int TW  = (DW > CSR_BITS + FRAC_BITS) ? DW : CSR_BITS + FRAC_BITS;
   localparam int D   = QB + 6;        // pipeline depth
   localparam int ODW = ((3*CB+7)/8)*8;

   localparam logic signed [RW-1:0] SAT_HI = {{(RW-CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      op_type               op;
      logic [2:0][CB-1:0]   p;
      logic [2:0][CB-1:0]   a;
      logic [2:0][CB-1:0]   n;
      status_type           stat;
      logic [2:0]           neg;
      logic [DW-1:0]        den;
   } pipe_type;

   logic [CSR_BITS-1:0]   mns_ff;
   logic                  vld_ff [D];
   pipe_type              ctl_ff [D-1];
   pipe_type              ctl_in [D-1];
   logic                  adv;

   logic [PW-1:0]         sq_ff   [3], sq_in   [3];
   logic signed [2*CB:0]  pr_ff   [3], pr_in   [3];
   logic signed [NW-1:0]  num_ff,      num_in;
   logic [NW-1:0]         anum_ff,     anum_in;
   logic [MW-1:0]         m_ff    [3], m_in    [3];
   logic [LH+MW-1:0]      lo_ff   [3], lo_in   [3];
   logic [HW+MW-1:0]      hi_ff   [3], hi_in   [3];
   logic [DW-1:0]         r_ff    [QB+1][3], r_in [QB+1][3];
   logic [QB-1:0]         x_ff    [QB+1][3], x_in [QB+1][3];
   logic [2:0][CB-1:0]    res_ff, res_in;
   status_type            st_ff, st_in;

   // advance the whole pipeline unless the result beat is stalled
   assign adv        = !vld_ff[D-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[D-1];
   assign rsp_tdata  = ODW'(res_ff);
   assign rsp_tuser  = st_ff;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         mns_ff <= CSR_RESET;
      end else if (csr_wr_en) begin
         mns_ff <= csr_wr_data;
      end
   end

   // capture, products and control through the front stages
   always_comb begin
      logic signed [CB-1:0]  pv, av, nv;
      logic signed [CB:0]    diff;
      logic signed [PW-1:0]  nsq;
      logic signed [2*CB:0]  dx, nx;
      logic signed [NW-1:0]  t0, t1, t2;
      logic [TW-1:0]         den_e, thr_e;
      logic [CB-1:0]         absn;
      ctl_in[0]      = ctl_ff[0];
      ctl_in[0].op   = op_type'(req_tuser);
      ctl_in[0].stat = ST_OK;
      ctl_in[0].neg  = '0;
      ctl_in[0].den  = '0;
      for (int i = 0; i < 3; i++) begin
         pv = req_tdata[i*CB +: CB];
         av = req_tdata[(3+i)*CB +: CB];
         nv = req_tdata[(6+i)*CB +: CB];
         ctl_in[0].p[i] = pv;
         ctl_in[0].a[i] = av;
         ctl_in[0].n[i] = nv;
         diff = $signed({pv[CB-1], pv}) - $signed({av[CB-1], av});
         nsq  = nv;
         sq_in[i] = PW'(nsq * nsq);
         dx = diff;
         nx = nv;
         pr_in[i] = dx * nx;
      end
      for (int k = 1; k < D-1; k++) ctl_in[k] = ctl_ff[k-1];

      // sum the dot products
      ctl_in[1].den = DW'(sq_ff[0]) + DW'(sq_ff[1]) + DW'(sq_ff[2]);
      t0 = pr_ff[0];
      t1 = pr_ff[1];
      t2 = pr_ff[2];
      num_in = t0 + t1 + t2;

      // classify, take magnitudes
      den_e = TW'(ctl_ff[1].den);
      thr_e = TW'({mns_ff, {FRAC_BITS{1'b0}}});
      if (ctl_ff[1].op == OP_INVALID) begin
         ctl_in[2].stat = ST_INVALID;
      end else if (ctl_ff[1].den == '0 || den_e < thr_e) begin
         ctl_in[2].stat = ST_DEGEN;
      end else begin
         ctl_in[2].stat = ST_OK;
      end
      anum_in = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      for (int i = 0; i < 3; i++) begin
         absn = ctl_ff[1].n[i][CB-1] ? CB'(-ctl_ff[1].n[i]) : ctl_ff[1].n[i];
         m_in[i] = (ctl_ff[1].op == OP_REFLECT) ? {absn, 1'b0} : {1'b0, absn};
         ctl_in[2].neg[i] = num_ff[NW-1] ^ ctl_ff[1].n[i][CB-1];
      end

      // split dividend multiply
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = anum_ff[LH-1:0] * m_ff[i];
         hi_in[i] = anum_ff[NW-1:LH] * m_ff[i];
      end
   end

   // join the dividend halves and seed the divider, then one restoring-division
   // step per stage, quotient bits shift into x
   always_comb begin
      logic [XW-1:0] xs;
      logic [DW:0]   sh, dd;
      logic          ge;
      for (int i = 0; i < 3; i++) begin
         xs = XW'(lo_ff[i]) + (XW'(hi_ff[i]) << LH);
         r_in[0][i] = DW'(xs[XW-1:QB]);
         x_in[0][i] = xs[QB-1:0];
      end
      for (int j = 1; j <= QB; j++) begin
         for (int i = 0; i < 3; i++) begin
            sh = {r_ff[j-1][i], x_ff[j-1][i][QB-1]};
            dd = {1'b0, ctl_ff[3+j].den};
            ge = (sh >= dd);
            r_in[j][i] = ge ? DW'(sh - dd) : sh[DW-1:0];
            x_in[j][i] = {x_ff[j-1][i][QB-2:0], ge};
         end
      end
   end

   // round, add to the anchor or subtract from the point, saturate
   always_comb begin
      logic                 rnd;
      logic [QB:0]          qr;
      logic signed [RW-1:0] tq, term, ae, pe, sum;
      pipe_type             c;
      c = ctl_ff[D-2];
      for (int i = 0; i < 3; i++) begin
         rnd  = ({r_ff[QB][i], 1'b0} >= {1'b0, c.den});
         qr   = (QB+1)'(x_ff[QB][i]) + (QB+1)'(rnd);
         tq   = RW'(qr);
         term = c.neg[i] ? -tq : tq;
         ae   = $signed(c.a[i]);
         pe   = $signed(c.p[i]);
         sum  = (c.op == OP_LINE) ? ae + term : pe - term;
         if (c.stat != ST_OK) begin
            res_in[i] = c.p[i];
         end else if (sum > SAT_HI) begin
            res_in[i] = SAT_HI[CB-1:0];
         end else if (sum < SAT_LO) begin
            res_in[i] = SAT_LO[CB-1:0];
         end else begin
            res_in[i] = sum[CB-1:0];
         end
      end
      st_in = c.stat;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < D; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < D; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < D-1; k++) ctl_ff[k] <= ctl_in[k];
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
            pr_ff[i] <= pr_in[i];
            m_ff[i]  <= m_in[i];
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
            for (int j = 0; j <= QB; j++) begin
               r_ff[j][i] <= r_in[j][i];
               x_ff[j][i] <= x_in[j][i];
            end
         end
         num_ff  <= num_in;
         anum_ff <= anum_in;
         res_ff  <= res_in;
         st_ff   <= st_in;
      end
   end

   // a result beat never carries the reserved status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_DEGEN ||
                      rsp_tuser == ST_INVALID))
      else $error("reserved status on result beat");

   // an item classed ok reaches rounding with a nonzero divisor
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[D-2] && ctl_ff[D-2].stat == ST_OK) |-> (ctl_ff[D-2].den != '0))
      else $error("ok item with zero N.N");

   // the quotient of an ok item stays inside its proven bound
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[D-2] && ctl_ff[D-2].stat == ST_OK) |->
         (!x_ff[QB][0][QB-1] && !x_ff[QB][1][QB-1] && !x_ff[QB][2][QB-1]))
      else $error("quotient out of range");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the 3D point projection and reflection block.
`timescale 1ns / 100ps

module testbench;
   import ppr3d_pkg::*;

   localparam int CB        = COORD_BITS_DEF;
   localparam int FB        = FRAC_BITS_DEF;
   localparam int REQ_W     = ((9*CB+7)/8)*8;
   localparam int RSP_W     = ((3*CB+7)/8)*8;
   localparam int IDLE_MAX  = 5000;
   localparam int DRAIN_CYC = 60;

   typedef struct packed {
      op_type           op;
      logic [REQ_W-1:0] data;
   } point_beat_type;

   typedef struct packed {
      logic [RSP_W-1:0] data;
      status_type       st;
   } coord_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic [1:0]         req_tuser = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic               csr_wr_en = 1'b0;
   logic [CSR_BITS-1:0] csr_wr_data = '0;

   point_beat_type pending_points[$];
   coord_beat_type expected_coords[$];
   point_beat_type cur_point;
   logic [CSR_BITS-1:0] min_norm_sq = CSR_RESET;
   int send_idle_pct = 38;
   int recv_idle_pct = 69;
   int fail_count = 0;
   int idle_cycles = 0;

   point_projection_reflection_3d DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Compute the projected or reflected point for one request beat
   function automatic coord_beat_type predict_projection(point_beat_type pb);
      logic signed [127:0] p[3], a[3], n[3], r[3];
      logic signed [127:0] den, num, anum, thr, x, q, rm, mg, hi, lo;
      logic num_neg;
      int k;
      coord_beat_type res;
      for (int i = 0; i < 3; i++) begin
         p[i] = $signed(pb.data[i*CB +: CB]);
         a[i] = $signed(pb.data[(3+i)*CB +: CB]);
         n[i] = $signed(pb.data[(6+i)*CB +: CB]);
         r[i] = p[i];
      end
      res.st = ST_OK;
      if (pb.op == OP_INVALID) begin
         res.st = ST_INVALID;
      end else begin
         den = 0;
         num = 0;
         for (int i = 0; i < 3; i++) begin
            den = den + n[i] * n[i];
            num = num + (p[i] - a[i]) * n[i];
         end
         thr = {96'b0, min_norm_sq};
         thr = thr <<< FB;
         if (den == 0 || den < thr) begin
            res.st = ST_DEGEN;
         end else begin
            k = (pb.op == OP_REFLECT) ? 2 : 1;
            num_neg = num < 0;
            anum = num_neg ? -num : num;
            for (int i = 0; i < 3; i++) begin
               mg = n[i] < 0 ? -n[i] : n[i];
               x = anum * mg * k;
               q = x / den;
               rm = x % den;
               // round half away from zero on the magnitude
               if (2 * rm >= den) q = q + 1;
               if (num_neg != (n[i] < 0)) q = -q;
               r[i] = (pb.op == OP_LINE) ? a[i] + q : p[i] - q;
            end
         end
      end
      hi = (128'sd1 <<< (CB-1)) - 1;
      lo = -hi - 1;
      for (int i = 0; i < 3; i++) begin
         if (r[i] > hi) r[i] = hi;
         if (r[i] < lo) r[i] = lo;
         res.data[i*CB +: CB] = r[i][CB-1:0];
      end
      return res;
   endfunction

   function automatic logic [CB-1:0] rand_coord(bit full);
      logic [CB-1:0] v;
      v = $urandom;
      if (!full) v = $signed(v) >>> $urandom_range(4, 26);
      return v;
   endfunction

   function automatic point_beat_type rand_point();
      point_beat_type pb;
      int sel;
      sel = $urandom_range(0, 99);
      pb.op = op_type'((sel < 8) ? OP_INVALID : $urandom_range(0, 2));
      for (int i = 0; i < 9; i++) pb.data[i*CB +: CB] = rand_coord(sel >= 80);
      // occasionally shrink the direction to probe the threshold
      if (sel >= 70 && sel < 76)
         for (int i = 6; i < 9; i++) pb.data[i*CB +: CB] = $signed(rand_coord(0)) >>> 12;
      return pb;
   endfunction

   function automatic point_beat_type make_point(op_type op, logic [CB-1:0] pv,
                                                 logic [CB-1:0] av,
                                                 logic [CB-1:0] nx, logic [CB-1:0] ny,
                                                 logic [CB-1:0] nz);
      point_beat_type pb;
      pb.op = op;
      for (int i = 0; i < 3; i++) begin
         pb.data[i*CB +: CB] = pv;
         pb.data[(3+i)*CB +: CB] = av;
      end
      pb.data[6*CB +: CB] = nx;
      pb.data[7*CB +: CB] = ny;
      pb.data[8*CB +: CB] = nz;
      return pb;
   endfunction

   task automatic report_mismatch(string what, logic [CB-1:0] exp_v, logic [CB-1:0] got_v);
      $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
      fail_count++;
   endtask

   // Present request beats and record the prediction of each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_coords.push_back(predict_projection(cur_point));
         if (!req_tvalid || req_tready) begin
            if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_point = pending_points.pop_front();
               req_tdata <= cur_point.data;
               req_tuser <= cur_point.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check each result beat against the oldest prediction
   always @(posedge clock) begin
      coord_beat_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_coords.size() == 0) begin
               report_mismatch("unexpected result beat", '0, rsp_tdata[CB-1:0]);
            end else begin
               e = expected_coords.pop_front();
               for (int i = 0; i < 3; i++)
                  if (rsp_tdata[i*CB +: CB] !== e.data[i*CB +: CB])
                     report_mismatch($sformatf("result coord %0d", i),
                                     e.data[i*CB +: CB], rsp_tdata[i*CB +: CB]);
               if (rsp_tuser !== e.st) report_mismatch("status", CB'(e.st), CB'(rsp_tuser));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // End the run if nothing moves for too long while work is outstanding
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_points.size() == 0 && expected_coords.size() == 0 && !req_tvalid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_threshold(logic [CSR_BITS-1:0] v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      min_norm_sq = v;
   endtask

   // wait on the falling edge so that every update of the rising edge has settled
   task automatic drain();
      while (pending_points.size() > 0 || req_tvalid || expected_coords.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) pending_points.push_back(rand_point());
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: extremes, each operation, degenerate and invalid cases
      for (int o = 0; o < 4; o++) begin
         pending_points.push_back(make_point(op_type'(o), 32'h0003_0000, 32'h0001_0000,
                                             32'h0001_0000, 32'h0000_0000, 32'h0000_0000));
         pending_points.push_back(make_point(op_type'(o), 32'h7fff_ffff, 32'h8000_0000,
                                             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
         pending_points.push_back(make_point(op_type'(o), 32'h8000_0000, 32'h7fff_ffff,
                                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      end
      // zero direction, exactly at threshold, just below threshold
      pending_points.push_back(make_point(OP_LINE, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0));
      pending_points.push_back(make_point(OP_PLANE, 32'h0002_0000, 32'h0,
                                          32'h0000_0100, 32'h0, 32'h0));
      pending_points.push_back(make_point(OP_REFLECT, 32'h0002_0000, 32'h0,
                                          32'h0000_00ff, 32'h0, 32'h0));
      pending_points.push_back(make_point(OP_REFLECT, 32'hffff_ffff, 32'h0000_0001,
                                          32'hffff_ffff, 32'h0000_0001, 32'h0000_0003));
      pending_points.push_back(make_point(OP_INVALID, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
      drain();

      run_random(160);

      send_idle_pct = 69;
      recv_idle_pct = 38;
      write_threshold(32'd0);
      run_random(180);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(32'hffff_ffff);
      run_random(180);

      write_threshold($urandom_range(0, 32'h0000_ffff));
      run_random(180);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
